// ===== sv/ist_pkg.sv =====
`default_nettype none
package ist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 2;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

// ===== sv/ist_req_if.sv =====
`default_nettype none
interface ist_req_if import ist_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/ist_rsp_if.sv =====
`default_nettype none
interface ist_rsp_if import ist_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [POS_W-1:0]          position;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        element_count;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;

    modport source (output valid, output found, output position, output status,
                    output element_count, output is_empty, output min_value,
                    output max_value, input ready);
    modport sink   (input valid, input found, input position, input status,
                    input element_count, input is_empty, input min_value,
                    input max_value, output ready);
endinterface
`default_nettype wire

// ===== sv/integer_set_table_unit.sv =====
// a request is taken in idle, then every live entry is read and compared in the scan,
// a remove that hits shifts the entries above the hit one place down, the finish step
// appends an inserted value and updates the count; one table entry is read per cycle
// through the single read port of the table memory
// throughput: one request at a time, the next is taken once the response is taken
// reset: element count cleared, table contents are left as they are (no clearing pass)
`default_nettype none
module integer_set_table_unit import ist_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ist_req_if.sink    i_req,
    ist_rsp_if.source  o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rdata;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic                      r_pend;
    logic [AW-1:0]             r_pidx;
    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_found;
    logic [AW-1:0]             r_pos;
    logic                      r_any;
    logic signed [VALUE_W-1:0] r_mn, r_mx;
    t_status                   r_status;

    // combinational control
    logic                      rd_en;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [AW-1:0]             raddr;
    logic                      full;
    logic                      append;
    logic                      inc_v;
    t_status                   n_status;
    logic [CW-1:0]             n_count;
    logic signed [VALUE_W-1:0] n_min, n_max;

    assign full   = (r_count == CW'(CAPACITY));
    assign append = (r_op == OP_INSERT) && !r_found && !full;
    assign raddr  = r_idx[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!rd_en && !r_pend) begin
                    if (r_op == OP_REMOVE && r_found) n_state = S_SHIFT;
                    else n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (!rd_en && !r_pend) n_state = S_FINISH;
            end
            S_FINISH: n_state = S_RESP;
            S_RESP: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        rd_en       = 1'b0;
        we          = 1'b0;
        waddr       = r_pidx - AW'(1);
        wdata       = r_rdata;
        case (r_state)
            S_IDLE:  i_req.ready = 1'b1;
            S_SCAN:  rd_en = (r_idx < r_count);
            S_SHIFT: begin
                rd_en = (r_idx < r_count);
                // entry i+1 lands one place down
                we    = r_pend;
            end
            S_FINISH: begin
                we    = append;
                waddr = r_count[AW-1:0];
                wdata = r_value;
            end
            S_RESP:  o_rsp.valid = 1'b1;
            default: ;
        endcase
    end

    // result of the request once the scan is over
    always_comb begin
        n_status = ST_DONE;
        n_count  = r_count;
        inc_v    = r_found;
        case (r_op)
            OP_INSERT: begin
                if (r_found) n_status = ST_NO_CHANGE;
                else if (full) n_status = ST_FULL;
                if (append) n_count = r_count + CW'(1);
                inc_v = r_found || !full;
            end
            OP_REMOVE: begin
                if (!r_found) n_status = ST_NO_CHANGE;
                else n_count = r_count - CW'(1);
                inc_v = 1'b0;
            end
            default: ;
        endcase
        if (n_count == '0) begin
            n_min = '0;
            n_max = '0;
        end else if (!r_any) begin
            n_min = r_value;
            n_max = r_value;
        end else if (inc_v) begin
            n_min = (r_value < r_mn) ? r_value : r_mn;
            n_max = (r_value > r_mx) ? r_value : r_mx;
        end else begin
            n_min = r_mn;
            n_max = r_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (r_state == S_FINISH) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_idx  <= r_idx + CW'(1);
            r_pidx <= r_idx[AW-1:0];
        end
        case (r_state)
            S_IDLE: begin
                r_op    <= i_req.op;
                r_value <= i_req.value;
                r_found <= 1'b0;
                r_pos   <= '0;
                r_any   <= 1'b0;
                r_idx   <= '0;
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (r_rdata == r_value) begin
                        r_found <= 1'b1;
                        r_pos   <= r_pidx;
                    end else begin
                        // extremes of everything but the requested value
                        if (!r_any || r_rdata < r_mn) r_mn <= r_rdata;
                        if (!r_any || r_rdata > r_mx) r_mx <= r_rdata;
                        r_any <= 1'b1;
                    end
                end
                if (n_state == S_SHIFT) r_idx <= CW'(r_pos) + CW'(1);
            end
            S_FINISH: begin
                r_status <= n_status;
                r_mn     <= n_min;
                r_mx     <= n_max;
            end
            default: ;
        endcase
    end

    assign o_rsp.found         = r_found;
    assign o_rsp.position      = r_found ? POS_W'(r_pos) : '0;
    assign o_rsp.status        = r_status;
    assign o_rsp.element_count = COUNT_W'(r_count);
    assign o_rsp.is_empty      = (r_count == '0);
    assign o_rsp.min_value     = r_mn;
    assign o_rsp.max_value     = r_mx;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while a response is pending");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && we) |-> (CW'(waddr) + CW'(1) < r_count))
        else $error("shift write outside the live entries");

    a_count_changes_on_finish: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && $past(r_state) != S_FINISH)
            |-> r_count == $past(r_count))
        else $error("element count changed outside the finish step");

    a_full_only_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_status == ST_FULL) |-> r_count == CW'(CAPACITY))
        else $error("table full reported below capacity");

endmodule
`default_nettype wire
